[rtl/core/ssev_pkg.sv]
// Shared constants, types and codes of the sprite scanline evaluator.
package ssev_pkg;

  // Sizing of the stores and the scan
  localparam int unsigned StoreBytes  = 256;
  localparam int unsigned MaxSprites  = 8;
  localparam int unsigned StepBudget  = 96;
  localparam int unsigned SpriteLimit = 64;
  localparam int unsigned SpriteBytes = 4;
  localparam int unsigned NumSlots    = 8;
  localparam int unsigned HeightTall  = 16;
  localparam int unsigned HeightShort = 8;
  localparam logic [7:0]  FillByte    = 8'hFF;

  // Derived widths
  localparam int unsigned AddrW     = $clog2(StoreBytes);
  localparam int unsigned RowW      = (MaxSprites > 1) ? $clog2(MaxSprites) : 1;
  localparam int unsigned CntW      = $clog2(MaxSprites + 1);
  localparam int unsigned StepW     = $clog2(StepBudget + 1);
  localparam int unsigned SlotW     = $clog2(NumSlots);
  localparam int unsigned LaneW     = $clog2(SpriteBytes);
  localparam int unsigned SpriteW   = 7;
  localparam int unsigned ScanAddrW = 10;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 48;

  // Kind of an input word
  typedef enum logic {
    OpWrite = 1'b0,
    OpEval  = 1'b1
  } op_e;

  // Scan registers that one step updates
  typedef struct packed {
    logic [SpriteW-1:0] sprite_num;
    logic [LaneW-1:0]   byte_num;
    logic [CntW-1:0]    copied;
    logic               done;
    logic               zero_seen;
    logic               overflow;
  } scan_t;

  // Write into the found store
  typedef struct packed {
    logic             we;
    logic [RowW-1:0]  row;
    logic [LaneW-1:0] lane;
    logic [7:0]       data;
  } fs_wr_t;

  // Input word payload, lowest field last
  typedef struct packed {
    logic [6:0] pad;
    logic [7:0] start_offset;
    logic [8:0] scanline;
    logic [7:0] store_data;
    logic [7:0] store_addr;
  } in_data_t;

  // Output word payload, lowest field last
  typedef struct packed {
    logic [6:0] pad;
    logic       first_sprite_in;
    logic       overflow;
    logic [3:0] sprites_found;
    logic [7:0] slot_x;
    logic [7:0] slot_attr;
    logic [7:0] slot_tile;
    logic [7:0] slot_y;
    logic [2:0] slot;
  } out_data_t;

endpackage

[rtl/core/sprite_scanline_evaluator_core.sv]
// Sprite scanline evaluator: top level with attribute store, scan sequencer and output register.
// After reset the block sweeps the attribute store to zero and accepts no word meanwhile.
// A write word (tuser 0) writes one store byte in the cycle it is accepted. An evaluate
// word (tuser 1) runs up to 96 scan steps; a step that reads the store passes an issue
// state (memory read), then an exec state (compare and update in the shared step unit),
// a step past the end of the store only marks the scan done, and a final issue state
// ends the scan. Eight slot words then leave at one per cycle while the downstream side
// is ready, the last one marked by tlast. The next input word is taken once the last
// slot word sits in the output register. tall_sprites is set with cfg_we_i; the user is
// to write it only while the block is idle, which the block itself does not enforce.
module sprite_scanline_evaluator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,   // tall_sprites
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // store_addr[7:0], store_data[15:8], scanline[24:16], start_offset[32:25], zero fill
  input  logic [ssev_pkg::InDataW-1:0]   s_axis_tdata,
  // op
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // slot[2:0], slot_y[10:3], slot_tile[18:11], slot_attr[26:19], slot_x[34:27],
  // sprites_found[38:35], overflow[39], first_sprite_in[40], zero fill
  output logic [ssev_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tlast
);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StIssue,
    StExec,
    StEmit
  } state_e;

  state_e                          state_q, state_d;
  logic [ssev_pkg::AddrW-1:0]      clr_q, clr_d;
  ssev_pkg::scan_t                 scan_q, scan_d;
  logic [ssev_pkg::StepW-1:0]      steps_q, steps_d;
  logic [8:0]                      line_q, line_d;
  logic [7:0]                      start_q, start_d;
  logic                            tall_q, tall_d;
  logic [ssev_pkg::SlotW-1:0]      slot_q, slot_d;
  logic                            out_valid_q, out_valid_d;
  ssev_pkg::out_data_t             out_data_q, out_data_d;
  logic                            out_last_q, out_last_d;

  ssev_pkg::in_data_t              in_data;
  logic                            in_acc;
  logic                            wr_acc;
  logic                            ev_acc;
  logic                            ram_we;
  logic [ssev_pkg::AddrW-1:0]      ram_waddr;
  logic [7:0]                      ram_wdata;
  logic [ssev_pkg::AddrW-1:0]      ram_raddr;
  logic [7:0]                      ram_rdata;
  logic                            addr_ok;
  ssev_pkg::scan_t                 step_st;
  ssev_pkg::fs_wr_t                step_wr;
  ssev_pkg::fs_wr_t                fs_wr;
  logic [ssev_pkg::SpriteBytes-1:0][7:0] slot_bytes;
  logic [4:0]                      cnt_ext;
  logic                            out_free;

  assign in_data       = ssev_pkg::in_data_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign wr_acc        = in_acc && (s_axis_tuser == ssev_pkg::OpWrite)
                       && (9'(in_data.store_addr) < 9'(ssev_pkg::StoreBytes));
  assign ev_acc        = in_acc && (s_axis_tuser == ssev_pkg::OpEval);

  // Attribute store: cleared by the sweep after reset, then written by write words
  assign ram_we    = (state_q == StClear) || wr_acc;
  assign ram_waddr = (state_q == StClear) ? clr_q
                                          : in_data.store_addr[ssev_pkg::AddrW-1:0];
  assign ram_wdata = (state_q == StClear) ? 8'h00 : in_data.store_data;

  ssev_ram #(
    .Width (8),
    .Depth (ssev_pkg::StoreBytes)
  ) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ssev_step_unit u_step (
    .st_i      (scan_q),
    .start_i   (start_q),
    .line_i    (line_q),
    .tall_i    (tall_q),
    .rd_byte_i (ram_rdata),
    .rd_addr_o (ram_raddr),
    .addr_ok_o (addr_ok),
    .st_o      (step_st),
    .fs_wr_o   (step_wr)
  );

  // Commit found store writes only on the cycle that applies a step
  always_comb begin
    fs_wr    = step_wr;
    fs_wr.we = step_wr.we && (state_q == StExec);
  end

  ssev_found_store u_found (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (ev_acc),
    .wr_i       (fs_wr),
    .rd_slot_i  (slot_q),
    .rd_bytes_o (slot_bytes)
  );

  assign cnt_ext  = 5'(scan_q.copied);
  assign out_free = !out_valid_q || m_axis_tready;

  // Sequencer: clear sweep, idle, step issue and apply, slot emission
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    steps_d     = steps_q;
    line_d      = line_q;
    start_d     = start_q;
    tall_d      = cfg_we_i ? cfg_wdata_i : tall_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    case (state_q)
      StClear: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == ssev_pkg::AddrW'(ssev_pkg::StoreBytes - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (ev_acc) begin
          line_d  = in_data.scanline;
          start_d = in_data.start_offset;
          scan_d  = '0;
          steps_d = '0;
          state_d = StIssue;
        end
      end
      StIssue: begin
        if (scan_q.done || (steps_q == ssev_pkg::StepW'(ssev_pkg::StepBudget))) begin
          slot_d  = '0;
          state_d = StEmit;
        end else if (!addr_ok) begin
          scan_d.done = 1'b1;
          steps_d     = steps_q + 1'b1;
        end else begin
          state_d = StExec;
        end
      end
      StExec: begin
        scan_d  = step_st;
        steps_d = steps_q + 1'b1;
        state_d = StIssue;
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d                = 1'b1;
          out_data_d.pad             = '0;
          out_data_d.slot            = 3'(slot_q);
          out_data_d.slot_y          = slot_bytes[0];
          out_data_d.slot_tile       = slot_bytes[1];
          out_data_d.slot_attr       = slot_bytes[2];
          out_data_d.slot_x          = slot_bytes[3];
          out_data_d.sprites_found   = (cnt_ext > 5'd15) ? 4'd15 : cnt_ext[3:0];
          out_data_d.overflow        = scan_q.overflow;
          out_data_d.first_sprite_in = scan_q.zero_seen;
          out_last_d = (slot_q == ssev_pkg::SlotW'(ssev_pkg::NumSlots - 1));
          slot_d     = slot_q + 1'b1;
          if (slot_q == ssev_pkg::SlotW'(ssev_pkg::NumSlots - 1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      scan_q      <= '0;
      steps_q     <= '0;
      line_q      <= '0;
      start_q     <= '0;
      tall_q      <= 1'b0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      scan_q      <= scan_d;
      steps_q     <= steps_d;
      line_q      <= line_d;
      start_q     <= start_d;
      tall_q      <= tall_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ssev_pkg::OutDataW'(out_data_q);
  assign m_axis_tlast  = out_last_q;

endmodule

[rtl/core/ssev_ram.sv]
// Generic single-port-write RAM with one registered read port.
module ssev_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry, register the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ssev_step_unit.sv]
// Shared scan step unit: address generation, range compare and step update.
module ssev_step_unit (
  input  ssev_pkg::scan_t                st_i,
  input  logic [7:0]                     start_i,
  input  logic [8:0]                     line_i,
  input  logic                           tall_i,
  input  logic [7:0]                     rd_byte_i,
  output logic [ssev_pkg::AddrW-1:0]     rd_addr_o,
  output logic                           addr_ok_o,
  output ssev_pkg::scan_t                st_o,
  output ssev_pkg::fs_wr_t               fs_wr_o
);

  logic [ssev_pkg::ScanAddrW-1:0] addr_full;
  logic [9:0]                     diff;
  logic [9:0]                     height;
  logic                           in_range;
  logic [ssev_pkg::SpriteW-1:0]   spr_inc;
  logic                           adv;

  // Byte address of the current step
  assign addr_full = ssev_pkg::ScanAddrW'(start_i)
                   + (ssev_pkg::ScanAddrW'(st_i.sprite_num) << ssev_pkg::LaneW)
                   + ssev_pkg::ScanAddrW'(st_i.byte_num);
  assign addr_ok_o = addr_full < ssev_pkg::ScanAddrW'(ssev_pkg::StoreBytes);
  assign rd_addr_o = addr_full[ssev_pkg::AddrW-1:0];

  // Range test: a Y above the line wraps negative and fails the compare
  assign diff     = {1'b0, line_i} - {2'b00, rd_byte_i};
  assign height   = tall_i ? 10'(ssev_pkg::HeightTall) : 10'(ssev_pkg::HeightShort);
  assign in_range = diff < height;
  assign spr_inc  = st_i.sprite_num + 1'b1;

  // Step update: copy phase while slots remain, overflow search after
  always_comb begin
    st_o         = st_i;
    adv          = 1'b0;
    fs_wr_o.we   = 1'b0;
    fs_wr_o.row  = ssev_pkg::RowW'(st_i.copied);
    fs_wr_o.lane = st_i.byte_num;
    fs_wr_o.data = rd_byte_i;
    if (st_i.copied < ssev_pkg::CntW'(ssev_pkg::MaxSprites)) begin
      fs_wr_o.we = 1'b1;
      if (st_i.byte_num == '0) begin
        if (in_range) begin
          st_o.byte_num = ssev_pkg::LaneW'(1);
        end else begin
          adv = 1'b1;
        end
      end else begin
        st_o.byte_num = st_i.byte_num + 1'b1;
        if (st_i.byte_num == ssev_pkg::LaneW'(ssev_pkg::SpriteBytes - 1)) begin
          if (st_i.sprite_num == '0) begin
            st_o.zero_seen = 1'b1;
          end
          st_o.copied = st_i.copied + 1'b1;
          adv         = 1'b1;
        end
      end
    end else begin
      if (in_range) begin
        st_o.overflow = 1'b1;
        st_o.done     = 1'b1;
      end else begin
        // diagonal advance: byte number moves without carry
        st_o.byte_num = st_i.byte_num + 1'b1;
        adv           = 1'b1;
      end
    end
    if (adv) begin
      st_o.sprite_num = spr_inc;
      if (spr_inc >= ssev_pkg::SpriteW'(ssev_pkg::SpriteLimit)) begin
        st_o.done = 1'b1;
      end
    end
  end

endmodule

[rtl/core/ssev_found_store.sv]
// Found sprite store: one register lane per sprite byte, with per-byte valid bits.
module ssev_found_store (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               clear_i,
  input  ssev_pkg::fs_wr_t                   wr_i,
  input  logic [ssev_pkg::SlotW-1:0]         rd_slot_i,
  output logic [ssev_pkg::SpriteBytes-1:0][7:0] rd_bytes_o
);

  logic [7:0]                    mem_q [ssev_pkg::SpriteBytes][ssev_pkg::MaxSprites];
  logic [ssev_pkg::MaxSprites-1:0] vld_q [ssev_pkg::SpriteBytes];
  logic [ssev_pkg::RowW-1:0]     rd_row;
  logic                          row_in;

  // Track written bytes; an unwritten byte reads as the fill byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < ssev_pkg::SpriteBytes; l++) begin
        vld_q[l] <= '0;
      end
    end else if (clear_i) begin
      for (int l = 0; l < ssev_pkg::SpriteBytes; l++) begin
        vld_q[l] <= '0;
      end
    end else if (wr_i.we) begin
      vld_q[wr_i.lane][wr_i.row] <= 1'b1;
    end
  end

  // Store the byte
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.lane][wr_i.row] <= wr_i.data;
    end
  end

  // Read one row across all lanes; slots past the store read as fill
  assign row_in = 32'(rd_slot_i) < ssev_pkg::MaxSprites;
  assign rd_row = ssev_pkg::RowW'(rd_slot_i);

  always_comb begin
    for (int l = 0; l < ssev_pkg::SpriteBytes; l++) begin
      rd_bytes_o[l] = (row_in && vld_q[l][rd_row]) ? mem_q[l][rd_row] : ssev_pkg::FillByte;
    end
  end

endmodule

[rtl/core/ssev_checker.sv]
// Port-level checks of the sprite scanline evaluator, bound to the top level.
module ssev_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ssev_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);

  // A stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // The last word of an evaluation is the final slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[2:0] == 3'd7)))
    else $error("tlast does not match the final slot");

  // Overflow only once every slot is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[39]
      |-> (m_axis_tdata[38:35] == 4'(ssev_pkg::MaxSprites)))
    else $error("overflow with free slots");

  // Sprite zero copied implies at least one sprite found
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[40] |-> (m_axis_tdata[38:35] != 4'd0))
    else $error("first sprite flagged with no sprite found");

endmodule

bind sprite_scanline_evaluator_core ssev_checker u_ssev_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
